[rtl/pfa_pkg.sv]
package pfa_pkg;

   // fixed field widths
   localparam int ACT_W     = 3;
   localparam int PAGE_IO_W = 10;
   localparam int STAT_W    = 2;
   localparam int REF_OUT_W = 16;
   localparam int CFG_W     = 11;
   localparam int CSR_IDX_W = 1;

   // defaults for the top level parameters
   localparam int DEF_MAX_PAGES = 1024;
   localparam int DEF_REF_BITS  = 16;

   // reset value of page_count
   localparam logic [CFG_W-1:0] PAGE_COUNT_RST = CFG_W'(1024);

   // actions
   localparam logic [ACT_W-1:0] ACT_INIT   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_ALLOC  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_FREE   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_INCREF = 3'd3;
   localparam logic [ACT_W-1:0] ACT_DECREF = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOMEM  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BADREF = 2'd2;
   localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED   = 1'd1;

   // count unit operations
   typedef enum logic [1:0] {
      ALU_PASS,
      ALU_INC,
      ALU_DEC
   } alu_op_type;

   // store write enables
   typedef struct packed {
      logic ref_we;
      logic link_we;
   } store_wr_type;

endpackage

[rtl/page_frame_allocator_refcount.sv]
// Alloc, free, incref, decref: the held request and the registered read of the count and link
// memories feed the update state, which goes through the shared count unit and loads the
// response word once the output is free. No new request is taken until then.
// Init walks the pages one a cycle, min(page_count, MAX_PAGES) of them.
// Reset: free list empty, page_count 1024, reserved_pages 0; counts undefined until init.
module page_frame_allocator_refcount #(
   parameter int MAX_PAGES = pfa_pkg::DEF_MAX_PAGES,
   parameter int REF_BITS  = pfa_pkg::DEF_REF_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [pfa_pkg::ACT_W-1:0]       req_action,
   input  logic [pfa_pkg::PAGE_IO_W-1:0]   req_page,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [pfa_pkg::STAT_W-1:0]      rsp_status,
   output logic [pfa_pkg::PAGE_IO_W-1:0]   rsp_page_out,
   output logic [pfa_pkg::REF_OUT_W-1:0]   rsp_ref_count,
   output logic                            rsp_released,
   // register write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pfa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pfa_pkg::CFG_W-1:0]       csr_wdata
);
   import pfa_pkg::*;

   localparam int PAGE_W = $clog2(MAX_PAGES);
   localparam int CNT_W  = $clog2(MAX_PAGES + 1);       // holds MAX_PAGES itself
   localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_INIT
   } state_type;

   // control
   state_type              state_ff, state_in;
   logic [CFG_W-1:0]       page_count_ff, page_count_in;
   logic [CFG_W-1:0]       reserved_ff, reserved_in;
   logic                   head_valid_ff, head_valid_in;
   logic [PAGE_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // held request
   logic [ACT_W-1:0]       act_ff, act_in;
   logic [PAGE_IO_W-1:0]   page_ff, page_in;
   logic [PAGE_W-1:0]      addr_ff, addr_in;

   // response word
   logic [STAT_W-1:0]      status_ff, status_in;
   logic [PAGE_IO_W-1:0]   page_out_ff, page_out_in;
   logic [REF_OUT_W-1:0]   ref_out_ff, ref_out_in;
   logic                   released_ff, released_in;

   // store and count unit
   store_wr_type           wr;
   logic [PAGE_W-1:0]      ref_waddr, ref_raddr, link_waddr;
   logic [REF_BITS-1:0]    ref_wdata, ref_rdata;
   logic [PAGE_W:0]        link_wdata, link_rdata;
   alu_op_type             alu_op;
   logic [REF_BITS-1:0]    cnt_out;
   logic                   cnt_zero, cnt_out_zero, lt;
   logic [CMP_W-1:0]       cmp_a, managed;
   logic                   out_free, in_reserved;

   // pages actually managed: min(page_count, MAX_PAGES)
   assign managed = (CMP_W'(page_count_ff) < CMP_W'(MAX_PAGES)) ?
                    CMP_W'(page_count_ff) : CMP_W'(MAX_PAGES);

   assign in_reserved = (CMP_W'(idx_ff) < CMP_W'(reserved_ff));
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // read address follows the request while idle, then holds for the update cycle
   assign ref_raddr = (state_ff == ST_IDLE) ?
                      ((req_action == ACT_ALLOC) ? head_ff : PAGE_W'(req_page)) : addr_ff;

   pfa_store #(
      .MAX_PAGES (MAX_PAGES),
      .REF_BITS  (REF_BITS),
      .PAGE_W    (PAGE_W)
   ) u_store (
      .clock      (clock),
      .wr         (wr),
      .ref_waddr  (ref_waddr),
      .ref_wdata  (ref_wdata),
      .ref_raddr  (ref_raddr),
      .ref_rdata  (ref_rdata),
      .link_waddr (link_waddr),
      .link_wdata (link_wdata),
      .link_raddr (head_ff),
      .link_rdata (link_rdata)
   );

   // one count unit: range and walk compares, saturating inc, dec
   pfa_alu #(
      .REF_BITS (REF_BITS),
      .CMP_W    (CMP_W)
   ) u_alu (
      .op           (alu_op),
      .cnt_in       (ref_rdata),
      .cmp_a        (cmp_a),
      .cmp_b        (managed),
      .cnt_out      (cnt_out),
      .cnt_zero     (cnt_zero),
      .cnt_out_zero (cnt_out_zero),
      .lt           (lt)
   );

   assign cmp_a = (state_ff == ST_INIT) ? CMP_W'(idx_ff) : CMP_W'(page_ff);

   always_comb begin
      state_in      = state_ff;
      page_count_in = page_count_ff;
      reserved_in   = reserved_ff;
      head_valid_in = head_valid_ff;
      head_in       = head_ff;
      idx_in        = idx_ff;
      act_in        = act_ff;
      page_in       = page_ff;
      addr_in       = addr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      status_in     = status_ff;
      page_out_in   = page_out_ff;
      ref_out_in    = ref_out_ff;
      released_in   = released_ff;
      wr            = '0;
      ref_waddr     = addr_ff;
      ref_wdata     = cnt_out;
      link_waddr    = addr_ff;
      link_wdata    = {head_valid_ff, head_ff};   // push: new entry points at old head
      alu_op        = ALU_PASS;

      // register writes
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PAGE_COUNT: page_count_in = csr_wdata;
            CSR_RESERVED:   reserved_in   = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               act_in  = req_action;
               page_in = req_page;
               addr_in = ref_raddr;
               if (req_action == ACT_INIT) begin
                  head_valid_in = 1'b0;
                  head_in       = '0;
                  idx_in        = '0;
                  state_in      = ST_INIT;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end

         ST_INIT: begin
            if (lt) begin
               // one page a cycle, ascending, so the highest free page ends at the head
               wr.ref_we = 1'b1;
               ref_waddr = idx_ff[PAGE_W-1:0];
               ref_wdata = REF_BITS'(in_reserved);
               if (!in_reserved) begin
                  wr.link_we    = 1'b1;
                  link_waddr    = idx_ff[PAGE_W-1:0];
                  head_in       = idx_ff[PAGE_W-1:0];
                  head_valid_in = 1'b1;
               end
               idx_in = idx_ff + CNT_W'(1);
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = STAT_OK;
               page_out_in  = '0;
               ref_out_in   = '0;
               released_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         ST_EXEC: begin
            unique case (act_ff)
               ACT_INCREF: alu_op = ALU_INC;
               ACT_DECREF: alu_op = ALU_DEC;
               default:    alu_op = ALU_PASS;
            endcase
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               status_in    = STAT_OK;
               page_out_in  = page_ff;
               ref_out_in   = '0;
               released_in  = 1'b0;
               if (act_ff == ACT_ALLOC) begin
                  if (!head_valid_ff) begin
                     status_in   = STAT_NOMEM;
                     page_out_in = '0;
                  end else begin
                     // pop: follow the link of the head page
                     page_out_in   = PAGE_IO_W'(head_ff);
                     ref_out_in    = REF_OUT_W'(ref_rdata);
                     head_in       = link_rdata[PAGE_W-1:0];
                     head_valid_in = link_rdata[PAGE_W];
                  end
               end else if (act_ff == ACT_FREE || act_ff == ACT_INCREF ||
                            act_ff == ACT_DECREF) begin
                  if (!lt) begin
                     status_in = STAT_RANGE;
                  end else begin
                     unique case (act_ff)
                        ACT_FREE: begin
                           if (!cnt_zero) begin
                              status_in  = STAT_BADREF;
                              ref_out_in = REF_OUT_W'(ref_rdata);
                           end else begin
                              wr.link_we    = 1'b1;
                              head_in       = addr_ff;
                              head_valid_in = 1'b1;
                           end
                        end
                        ACT_INCREF: begin
                           wr.ref_we  = 1'b1;
                           ref_out_in = REF_OUT_W'(cnt_out);
                        end
                        ACT_DECREF: begin
                           if (cnt_zero) begin
                              status_in = STAT_BADREF;
                           end else begin
                              wr.ref_we  = 1'b1;
                              ref_out_in = REF_OUT_W'(cnt_out);
                              if (cnt_out_zero) begin
                                 // last reference gone: back on the free list
                                 wr.link_we    = 1'b1;
                                 head_in       = addr_ff;
                                 head_valid_in = 1'b1;
                                 released_in   = 1'b1;
                              end
                           end
                        end
                        default: ;
                     endcase
                  end
               end else begin
                  // unknown action: all-zero word
                  page_out_in = '0;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         page_count_ff <= PAGE_COUNT_RST;
         reserved_ff   <= '0;
         head_valid_ff <= 1'b0;
         head_ff       <= '0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         page_count_ff <= page_count_in;
         reserved_ff   <= reserved_in;
         head_valid_ff <= head_valid_in;
         head_ff       <= head_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      act_ff      <= act_in;
      page_ff     <= page_in;
      addr_ff     <= addr_in;
      status_ff   <= status_in;
      page_out_ff <= page_out_in;
      ref_out_ff  <= ref_out_in;
      released_ff <= released_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_page_out  = page_out_ff;
   assign rsp_ref_count = ref_out_ff;
   assign rsp_released  = released_ff;

   // a taken request always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != ST_IDLE)
      else $error("accepted word did not start work");

   // a new response word only comes out of a work state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_in && !(rsp_valid_ff && rsp_stall) |-> state_ff != ST_IDLE)
      else $error("response word loaded while idle");

   // init writes only pages below the managed count
   a_init_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INIT && wr.ref_we |-> lt)
      else $error("init wrote past managed pages");

   // release is only reported with an ok status and a zero count
   a_release_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_released |-> rsp_status == STAT_OK && rsp_ref_count == '0)
      else $error("release with bad status or count");

endmodule

[rtl/pfa_alu.sv]
module pfa_alu #(
   parameter int REF_BITS = 16,
   parameter int CMP_W    = 11
) (
   input  pfa_pkg::alu_op_type  op,
   input  logic [REF_BITS-1:0]  cnt_in,
   input  logic [CMP_W-1:0]     cmp_a,
   input  logic [CMP_W-1:0]     cmp_b,
   output logic [REF_BITS-1:0]  cnt_out,
   output logic                 cnt_zero,
   output logic                 cnt_out_zero,
   output logic                 lt
);
   import pfa_pkg::*;

   localparam logic [REF_BITS-1:0] CNT_MAX = '1;

   always_comb begin
      unique case (op)
         ALU_INC: cnt_out = (cnt_in == CNT_MAX) ? cnt_in : cnt_in + REF_BITS'(1);
         ALU_DEC: cnt_out = cnt_in - REF_BITS'(1);
         default: cnt_out = cnt_in;
      endcase
   end

   assign cnt_zero     = (cnt_in == '0);
   assign cnt_out_zero = (cnt_out == '0);
   assign lt           = (cmp_a < cmp_b);

endmodule

[rtl/pfa_store.sv]
module pfa_store #(
   parameter int MAX_PAGES = 1024,
   parameter int REF_BITS  = 16,
   parameter int PAGE_W    = 10
) (
   input  logic                clock,
   input  pfa_pkg::store_wr_type wr,
   input  logic [PAGE_W-1:0]   ref_waddr,
   input  logic [REF_BITS-1:0] ref_wdata,
   input  logic [PAGE_W-1:0]   ref_raddr,
   output logic [REF_BITS-1:0] ref_rdata,
   input  logic [PAGE_W-1:0]   link_waddr,
   input  logic [PAGE_W:0]     link_wdata,
   input  logic [PAGE_W-1:0]   link_raddr,
   output logic [PAGE_W:0]     link_rdata
);
   import pfa_pkg::*;

   logic [REF_BITS-1:0] ref_mem  [MAX_PAGES];
   logic [PAGE_W:0]     link_mem [MAX_PAGES];   // {valid, next page}
   logic [REF_BITS-1:0] ref_rd_ff;
   logic [PAGE_W:0]     link_rd_ff;

   always_ff @(posedge clock) begin
      if (wr.ref_we) begin
         ref_mem[ref_waddr] <= ref_wdata;
      end
      ref_rd_ff <= ref_mem[ref_raddr];
   end

   always_ff @(posedge clock) begin
      if (wr.link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff <= link_mem[link_raddr];
   end

   assign ref_rdata  = ref_rd_ff;
   assign link_rdata = link_rd_ff;

endmodule

[verif/pfa_frame_checker.sv]
`timescale 1ns / 100ps

module pfa_frame_checker #(
   parameter int MAX_PAGES = pfa_pkg::DEF_MAX_PAGES,
   parameter int REF_BITS  = pfa_pkg::DEF_REF_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [pfa_pkg::ACT_W-1:0]       req_action,
   input  logic [pfa_pkg::PAGE_IO_W-1:0]   req_page,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [pfa_pkg::STAT_W-1:0]      rsp_status,
   input  logic [pfa_pkg::PAGE_IO_W-1:0]   rsp_page_out,
   input  logic [pfa_pkg::REF_OUT_W-1:0]   rsp_ref_count,
   input  logic                            rsp_released,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [pfa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pfa_pkg::CFG_W-1:0]       csr_wdata,
   output int                              mismatches,
   output int                              words_due
);
   import pfa_pkg::*;

   typedef struct packed {
      logic [STAT_W-1:0]    status;
      logic [PAGE_IO_W-1:0] page_out;
      logic [REF_OUT_W-1:0] ref_count;
      logic                 released;
   } frame_word_type;

   localparam logic [REF_BITS-1:0] COUNT_MAX = '1;

   // shadow of the allocator
   logic [CFG_W-1:0]     page_count;
   logic [CFG_W-1:0]     reserved_pages;
   logic                 head_ok;
   logic [PAGE_IO_W-1:0] head;
   logic                 link_ok [MAX_PAGES];
   logic [PAGE_IO_W-1:0] link    [MAX_PAGES];
   logic [REF_BITS-1:0]  counts  [MAX_PAGES];

   frame_word_type       due_words [$];
   frame_word_type       want;
   frame_word_type       got;

   function automatic int unsigned managed_pages();
      return (page_count < MAX_PAGES) ? page_count : MAX_PAGES;
   endfunction

   function automatic void push_free(input logic [PAGE_IO_W-1:0] pg);
      link_ok[pg] = head_ok;
      link[pg]    = head;
      head_ok     = 1'b1;
      head        = pg;
   endfunction

   function automatic frame_word_type make_word(input logic [STAT_W-1:0] st,
                                                input logic [PAGE_IO_W-1:0] pg,
                                                input logic [REF_BITS-1:0] rc,
                                                input logic rel);
      frame_word_type w;
      w.status    = st;
      w.page_out  = pg;
      w.ref_count = REF_OUT_W'(rc);
      w.released  = rel;
      return w;
   endfunction

   function automatic frame_word_type frame_step(input logic [ACT_W-1:0] act,
                                                 input logic [PAGE_IO_W-1:0] pg);
      int unsigned          n;
      logic [REF_BITS-1:0]  rc;
      logic [PAGE_IO_W-1:0] popped;
      n = managed_pages();
      case (act) inside
         ACT_INIT: begin
            head_ok = 1'b0;
            head    = '0;
            for (int i = 0; i < n; i++) begin
               if (i < reserved_pages) begin
                  counts[i] = REF_BITS'(1);
               end else begin
                  counts[i] = '0;
                  push_free(PAGE_IO_W'(i));
               end
            end
            return make_word(STAT_OK, '0, '0, 1'b0);
         end
         ACT_ALLOC: begin
            if (!head_ok)
               return make_word(STAT_NOMEM, '0, '0, 1'b0);
            popped  = head;
            head_ok = link_ok[popped];
            head    = link[popped];
            return make_word(STAT_OK, popped, counts[popped], 1'b0);
         end
         ACT_FREE, ACT_INCREF, ACT_DECREF: begin
            if (pg >= n)
               return make_word(STAT_RANGE, pg, '0, 1'b0);
            rc = counts[pg];
            if (act == ACT_FREE) begin
               if (rc != '0)
                  return make_word(STAT_BADREF, pg, rc, 1'b0);
               push_free(pg);
               return make_word(STAT_OK, pg, '0, 1'b0);
            end
            if (act == ACT_INCREF) begin
               if (rc != COUNT_MAX)
                  rc = rc + 1'b1;
               counts[pg] = rc;
               return make_word(STAT_OK, pg, rc, 1'b0);
            end
            if (rc == '0)
               return make_word(STAT_BADREF, pg, '0, 1'b0);
            rc = rc - 1'b1;
            counts[pg] = rc;
            if (rc == '0) begin
               push_free(pg);
               return make_word(STAT_OK, pg, '0, 1'b1);
            end
            return make_word(STAT_OK, pg, rc, 1'b0);
         end
         default: return make_word(STAT_OK, '0, '0, 1'b0);
      endcase
   endfunction

   function automatic void check_field(input string name, input int unsigned want_v,
                                       input int unsigned got_v);
      if (want_v != got_v) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         page_count     = PAGE_COUNT_RST;
         reserved_pages = '0;
         head_ok        = 1'b0;
         head           = '0;
         for (int i = 0; i < MAX_PAGES; i++)
            link_ok[i] = 1'b0;
         due_words.delete();
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PAGE_COUNT)
               page_count = csr_wdata;
            else
               reserved_pages = csr_wdata;
         end
         // the word leaving now was predicted earlier, so compare before predicting
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_page_out, rsp_ref_count, rsp_released};
            if (due_words.size() == 0) begin
               $display({"%0t: unexpected word: expected none, ",
                         "actual status %0d page %0d ref %0d rel %0d"},
                        $time, got.status, got.page_out, got.ref_count, got.released);
               mismatches++;
            end else begin
               want = due_words.pop_front();
               check_field("status", want.status, got.status);
               check_field("page_out", want.page_out, got.page_out);
               check_field("ref_count", want.ref_count, got.ref_count);
               check_field("released", want.released, got.released);
            end
         end
         if (req_valid && !req_stall)
            due_words.push_back(frame_step(req_action, req_page));
      end
      words_due = due_words.size();
   end

endmodule

[verif/page_frame_allocator_refcount_test.sv]
`timescale 1ns / 100ps

module page_frame_allocator_refcount_test;
   import pfa_pkg::*;

   // block built at its default count width
   localparam int REF_BITS_TB  = DEF_REF_BITS;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 1850;
   localparam int GAP_MAX      = 17;
   localparam int TOP_PAGE     = 1023;

   // undefined actions: the block answers with an all-zero word
   localparam logic [ACT_W-1:0] ACT_RSVD_LO = 3'd5;
   localparam logic [ACT_W-1:0] ACT_RSVD_HI = 3'd7;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [ACT_W-1:0]     req_action = ACT_INIT;
   logic [PAGE_IO_W-1:0] req_page  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [STAT_W-1:0]    rsp_status;
   logic [PAGE_IO_W-1:0] rsp_page_out;
   logic [REF_OUT_W-1:0] rsp_ref_count;
   logic                 rsp_released;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_PAGE_COUNT;
   logic [CFG_W-1:0]     csr_wdata = '0;

   int mismatches;
   int words_due;
   int cycles      = 0;
   int src_quiet   = 0;   // items left in a back-to-back stretch, sender side
   int sink_quiet  = 0;   // same for the receiving side

   page_frame_allocator_refcount #(
      .MAX_PAGES(DEF_MAX_PAGES),
      .REF_BITS (REF_BITS_TB)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_page     (req_page),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_page_out (rsp_page_out),
      .rsp_ref_count(rsp_ref_count),
      .rsp_released (rsp_released),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // watches all three channels, predicts each word and compares
   pfa_frame_checker #(
      .MAX_PAGES(DEF_MAX_PAGES),
      .REF_BITS (REF_BITS_TB)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_page     (req_page),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_page_out (rsp_page_out),
      .rsp_ref_count(rsp_ref_count),
      .rsp_released (rsp_released),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .words_due    (words_due)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // watchdog: a hung handshake or a lost word ends here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Idle cycles before the next word. Now and then a stretch of zero gaps is
   // started, so that full throughput is exercised as well as sparse traffic.
   task automatic draw_gap(inout int quiet_left, output int gap);
      if (quiet_left > 0) begin
         quiet_left--;
         gap = 0;
      end else if ($urandom_range(39, 0) == 0) begin
         quiet_left = $urandom_range(60, 15);
         gap = 0;
      end else begin
         gap = $urandom_range(GAP_MAX, 0);
      end
   endtask

   // Receiving side: stall for a random number of cycles, then take one word.
   // The stall is drawn whether or not a word is waiting, so it lands on every
   // phase of the block's work, init walks included.
   initial begin
      int hold;
      while (reset) @(negedge clock);
      forever begin
         draw_gap(sink_quiet, hold);
         if (hold > 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Called and returns at a falling edge. Valid stays high across back-to-back
   // words, so it is never dropped and raised within one step.
   task automatic send_word(input logic [ACT_W-1:0] act, input logic [PAGE_IO_W-1:0] pg);
      int gap;
      draw_gap(src_quiet, gap);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  = 1'b1;
      req_action = act;
      req_page   = pg;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // hold off until every predicted word has come back, then let the block settle
   task automatic drain();
      req_valid = 1'b0;
      while (words_due != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // new geometry: registers only change while idle, and init always follows
   // so that no count is read before it has been set
   task automatic start_phase(input logic [CFG_W-1:0] pages, input logic [CFG_W-1:0] rsvd);
      drain();
      if ($urandom_range(1, 0)) begin
         write_reg(CSR_PAGE_COUNT, pages);
         write_reg(CSR_RESERVED, rsvd);
      end else begin
         write_reg(CSR_RESERVED, rsvd);
         write_reg(CSR_PAGE_COUNT, pages);
      end
      send_word(ACT_INIT, PAGE_IO_W'($urandom_range(TOP_PAGE, 0)));
   endtask

   function automatic logic [ACT_W-1:0] ACT_ACT_RSVD_PICK();
      return ACT_W'($urandom_range(ACT_RSVD_HI, ACT_RSVD_LO));
   endfunction

   // One random request. In a climbing phase increfs dominate so that counts
   // run high; otherwise alloc/free/ref traffic is balanced.
   task automatic random_word(input int unsigned n, input bit climb,
                              output logic [ACT_W-1:0] act, output logic [PAGE_IO_W-1:0] pg);
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < (climb ? 12 : 25))
         act = ACT_ALLOC;
      else if (roll < (climb ? 20 : 40))
         act = ACT_FREE;
      else if (roll < (climb ? 68 : 65))
         act = ACT_INCREF;
      else if (roll < 93)
         act = ACT_DECREF;
      else if (roll < 97)
         act = ACT_INIT;
      else
         act = ACT_ACT_RSVD_PICK();
      // mostly managed pages; now and then anything, which covers out of range
      if ($urandom_range(9, 0) == 0)
         pg = PAGE_IO_W'($urandom_range(TOP_PAGE, 0));
      else
         pg = PAGE_IO_W'($urandom_range(n - 1, 0));
   endtask

   initial begin
      int               sent;
      int               phase_len;
      int unsigned      n;
      bit               climb;
      logic [CFG_W-1:0] pages;
      logic [CFG_W-1:0] rsvd;
      logic [ACT_W-1:0] act;
      logic [PAGE_IO_W-1:0] pg;

      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Reset geometry: 1024 pages, none reserved. Head of list is page 1023.
      send_word(ACT_INIT, '0);
      send_word(ACT_ALLOC, 10'h3FF);
      send_word(ACT_ALLOC, '0);
      send_word(ACT_INCREF, 10'd1023);
      send_word(ACT_DECREF, 10'd1023);     // back to zero, released onto the list
      send_word(ACT_FREE, 10'd1022);
      send_word(ACT_FREE, 10'd1023);       // double free, list now holds it twice
      send_word(ACT_ALLOC, '0);
      send_word(ACT_INCREF, 10'd5);
      send_word(ACT_FREE, 10'd5);          // free while still referenced
      send_word(ACT_DECREF, 10'd7);        // decref of an unreferenced page
      send_word(ACT_RSVD_LO, 10'h2AA);
      send_word(ACT_W'(ACT_RSVD_LO + 1), 10'h155);
      send_word(ACT_RSVD_HI, 10'h3FF);

      // Four pages, two reserved: list runs dry, range and bad count errors.
      start_phase(11'd4, 11'd2);
      send_word(ACT_ALLOC, '0);
      send_word(ACT_ALLOC, '0);
      send_word(ACT_ALLOC, '0);            // no free page
      send_word(ACT_FREE, 10'd1000);       // beyond the managed pages
      send_word(ACT_DECREF, 10'd3);
      send_word(ACT_INCREF, 10'd0);

      // One page, more reserved than managed: everything referenced, list empty.
      start_phase(11'd1, 11'd1024);
      send_word(ACT_ALLOC, '0);
      send_word(ACT_DECREF, '0);
      send_word(ACT_ALLOC, '0);

      // Random phases, mostly small geometries since init walks every page.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(15, 0))
            0:       pages = 11'd1024;
            1:       pages = CFG_W'($urandom_range(1024, 1));
            default: pages = CFG_W'($urandom_range(48, 1));
         endcase
         case ($urandom_range(9, 0))
            0:       rsvd = '0;
            1:       rsvd = 11'd1024;
            2:       rsvd = CFG_W'($urandom_range(1024, 0));
            default: rsvd = CFG_W'($urandom_range(pages / 2 + 1, 0));
         endcase
         n         = (pages < DEF_MAX_PAGES) ? pages : DEF_MAX_PAGES;
         climb     = ($urandom_range(2, 0) == 0);
         phase_len = $urandom_range(150, 50);
         start_phase(pages, rsvd);
         sent++;
         repeat (phase_len) begin
            random_word(n, climb, act, pg);
            send_word(act, pg);
            if (act < ACT_RSVD_LO)
               sent++;
         end
      end

      drain();
      repeat (16) @(negedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[page_frame_allocator_refcount.f]
rtl/pfa_pkg.sv
rtl/pfa_alu.sv
rtl/pfa_store.sv
rtl/page_frame_allocator_refcount.sv
verif/pfa_frame_checker.sv
verif/page_frame_allocator_refcount_test.sv
